// ===== design/dltq_pkg.sv =====
// Shared types and constants for the delta-list timeout queue.
package dltq_pkg;

  localparam int DELTA_W  = 16;
  localparam int HANDLE_W = 8;
  localparam int ARG_W    = 32;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [DELTA_W-1:0]  delta;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
  } entry_t;

  typedef struct packed {
    logic ge;
    logic eq;
    logic a_zero;
  } alu_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_PLACE,
    ST_SCAN,
    ST_FIRE,
    ST_COPY,
    ST_RESP
  } state_t;

endpackage

// ===== design/dltq_mem.sv =====
// Entry store of the timeout table: one write port and one registered read port.
module dltq_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  dltq_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output dltq_pkg::entry_t rd_data
);
  import dltq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/dltq_alu.sv =====
// Shared delta unit: one subtractor with its compare and zero flags.
module dltq_alu (
  input  logic [dltq_pkg::DELTA_W-1:0] a,
  input  logic [dltq_pkg::DELTA_W-1:0] b,
  output logic [dltq_pkg::DELTA_W-1:0] diff,
  output dltq_pkg::alu_flags_t         flags
);
  import dltq_pkg::*;

  logic [DELTA_W:0] wide;

  assign wide         = {1'b0, a} - {1'b0, b};
  assign diff         = wide[DELTA_W-1:0];
  assign flags.ge     = !wide[DELTA_W];
  assign flags.eq     = (a == b);
  assign flags.a_zero = (a == '0);

endmodule

// ===== design/delta_list_timeout_queue.sv =====
// Top level of the delta-list timeout queue: sequencer, output register and assertions.
//
// Requests arrive on the input channel (in_valid/in_ready) and results leave on
// the output channel (out_valid/out_ready). One request is worked on at a time;
// in_ready is high only while the sequencer is idle.
// An insert walks the table one entry per cycle through the shared subtractor,
// then moves the later entries up one slot per cycle. It gives one result.
// A tick scans leading entries one per cycle to find and decrement the first
// positive delta. If it fires, every expired entry is read and presented one per
// cycle while the output register is free, and the remaining entries are then
// moved down one per cycle. Each result sits in an output register; the
// sequencer may finish and take the next request while the last result still
// waits. When the receiver stalls, firing pauses until the register is free.
// Reset empties the table at once; the entry store needs no clearing pass, as
// only stored entries are read.
module delta_list_timeout_queue #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic                          masked,
  input  logic [dltq_pkg::HANDLE_W-1:0] handle,
  input  logic [dltq_pkg::ARG_W-1:0]    argument,
  input  logic [dltq_pkg::DELTA_W-1:0]  delay_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fired,
  output logic [dltq_pkg::HANDLE_W-1:0] fired_handle,
  output logic [dltq_pkg::ARG_W-1:0]    fired_argument,
  output logic                          overflow,
  output logic                          last
);
  import dltq_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       pos, pos_next;
  logic [CW-1:0]       kcnt, kcnt_next;
  logic [DELTA_W-1:0]  tval, tval_next;
  logic [HANDLE_W-1:0] hreg, hreg_next;
  logic [ARG_W-1:0]    areg, areg_next;
  logic                masked_r, masked_next;
  logic                dec_r, dec_next;
  logic                resp_ovf, resp_ovf_next;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic [AW-1:0]       rd_addr;
  entry_t              rd_data;

  logic [DELTA_W-1:0]  alu_a, alu_b, alu_diff;
  alu_flags_t          flags;

  logic                in_acc, slot_free, full, empty;
  logic                idx_end, fire_end, copy_end, shift_end, scan_zero;
  logic [CW-1:0]       idx_inc, pos_inc, pos_dec, cnt_dec, copy_dst;

  logic                load_out;
  logic                ld_fired, ld_overflow, ld_last;
  logic [HANDLE_W-1:0] ld_handle;
  logic [ARG_W-1:0]    ld_argument;

  dltq_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dltq_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (alu_diff),
    .flags (flags)
  );

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign full      = (cnt == CW'(TABLE_DEPTH));
  assign empty     = (cnt == '0);
  assign idx_inc   = idx + 1'b1;
  assign pos_inc   = pos + 1'b1;
  assign pos_dec   = pos - 1'b1;
  assign cnt_dec   = cnt - 1'b1;
  assign copy_dst  = pos - kcnt;
  assign idx_end   = (idx_inc == cnt);
  assign fire_end  = (idx_inc == kcnt);
  assign copy_end  = (pos_inc == cnt);
  assign shift_end = (pos == idx);
  assign scan_zero = flags.a_zero || (!dec_r && flags.eq);

  always_comb begin
    unique case (state)
      ST_WALK: begin
        alu_a = tval;
        alu_b = rd_data.delta;
      end
      ST_SCAN: begin
        alu_a = rd_data.delta;
        alu_b = DELTA_W'(1);
      end
      default: begin
        alu_a = rd_data.delta;
        alu_b = tval;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode == OP_INSERT) begin
            if (full) begin
              state_next = ST_RESP;
            end else if (empty) begin
              state_next = ST_PLACE;
            end else begin
              state_next = ST_WALK;
            end
          end else begin
            state_next = empty ? ST_RESP : ST_SCAN;
          end
        end
      end
      ST_WALK: begin
        if (flags.ge) begin
          if (idx_end) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (shift_end) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_next = ST_RESP;
      end
      ST_SCAN: begin
        if (!flags.a_zero && masked_r) begin
          state_next = ST_RESP;
        end else if (scan_zero) begin
          if (idx_end) begin
            state_next = masked_r ? ST_RESP : ST_FIRE;
          end
        end else begin
          state_next = (idx == '0) ? ST_RESP : ST_FIRE;
        end
      end
      ST_FIRE: begin
        if (slot_free && fire_end) begin
          state_next = (kcnt == cnt) ? ST_IDLE : ST_COPY;
        end
      end
      ST_COPY: begin
        if (copy_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_next      = cnt;
    idx_next      = idx;
    pos_next      = pos;
    kcnt_next     = kcnt;
    tval_next     = tval;
    hreg_next     = hreg;
    areg_next     = areg;
    masked_next   = masked_r;
    dec_next      = dec_r;
    resp_ovf_next = resp_ovf;
    wr_en         = 1'b0;
    wr_addr       = idx[AW-1:0];
    wr_data       = rd_data;
    rd_addr       = idx[AW-1:0];
    load_out      = 1'b0;
    ld_fired      = 1'b0;
    ld_handle     = '0;
    ld_argument   = '0;
    ld_overflow   = 1'b0;
    ld_last       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        idx_next      = '0;
        rd_addr       = '0;
        tval_next     = delay_ticks;
        hreg_next     = handle;
        areg_next     = argument;
        masked_next   = masked;
        dec_next      = 1'b0;
        resp_ovf_next = (opcode == OP_INSERT) && full;
      end
      ST_WALK: begin
        if (flags.ge) begin
          tval_next = alu_diff;
          idx_next  = idx_inc;
          rd_addr   = idx_inc[AW-1:0];
        end else begin
          pos_next = cnt_dec;
          rd_addr  = cnt_dec[AW-1:0];
        end
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos_inc[AW-1:0];
        if (shift_end) begin
          wr_data.delta = alu_diff;
        end else begin
          pos_next = pos_dec;
          rd_addr  = pos_dec[AW-1:0];
        end
      end
      ST_PLACE: begin
        wr_en            = 1'b1;
        wr_addr          = idx[AW-1:0];
        wr_data.delta    = tval;
        wr_data.handle   = hreg;
        wr_data.argument = areg;
        cnt_next         = cnt + 1'b1;
      end
      ST_SCAN: begin
        if (!flags.a_zero && !dec_r) begin
          wr_en         = 1'b1;
          wr_data.delta = alu_diff;
          dec_next      = 1'b1;
        end
        if (scan_zero && !(masked_r && !flags.a_zero)) begin
          if (idx_end) begin
            kcnt_next = cnt;
            idx_next  = '0;
            rd_addr   = '0;
          end else begin
            idx_next = idx_inc;
            rd_addr  = idx_inc[AW-1:0];
          end
        end else begin
          kcnt_next = idx;
          idx_next  = '0;
          rd_addr   = '0;
        end
      end
      ST_FIRE: begin
        if (slot_free) begin
          load_out    = 1'b1;
          ld_fired    = 1'b1;
          ld_handle   = rd_data.handle;
          ld_argument = rd_data.argument;
          ld_last     = fire_end;
          if (fire_end) begin
            pos_next = kcnt;
            rd_addr  = kcnt[AW-1:0];
            if (kcnt == cnt) begin
              cnt_next = '0;
            end
          end else begin
            idx_next = idx_inc;
            rd_addr  = idx_inc[AW-1:0];
          end
        end
      end
      ST_COPY: begin
        wr_en   = 1'b1;
        wr_addr = copy_dst[AW-1:0];
        if (copy_end) begin
          cnt_next = cnt - kcnt;
        end else begin
          pos_next = pos_inc;
          rd_addr  = pos_inc[AW-1:0];
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          load_out    = 1'b1;
          ld_overflow = resp_ovf;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pos      <= pos_next;
    kcnt     <= kcnt_next;
    tval     <= tval_next;
    hreg     <= hreg_next;
    areg     <= areg_next;
    masked_r <= masked_next;
    dec_r    <= dec_next;
    resp_ovf <= resp_ovf_next;
    if (load_out) begin
      fired          <= ld_fired;
      fired_handle   <= ld_handle;
      fired_argument <= ld_argument;
      overflow       <= ld_overflow;
      last           <= ld_last;
    end
  end

  // The table never holds more entries than it has slots.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // An insert into a full table leaves the table untouched.
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_INSERT && full) |=> (state == ST_RESP && $stable(cnt)))
    else $error("insert into full table changed the table");

  // Firing only reads stored entries.
  a_fire_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIRE) |-> (idx < kcnt && kcnt <= cnt && kcnt != '0))
    else $error("fire index outside stored entries");

  // Walking and scanning stay within the stored entries.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK || state == ST_SCAN) |-> (idx < cnt))
    else $error("scan index outside stored entries");

  // A new result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(fired_handle) && $stable(last)))
    else $error("pending result overwritten");

endmodule
